>>> src/wsp_pkg.sv
// ============================================================================
// wsp_pkg: shared types and constants for the screen projection block
// Field widths, register codes, reset values and the multiplier tag type.
// ============================================================================
package wsp_pkg;

    // Item field widths
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 4;
    localparam int PIX_W     = 16;
    localparam int MAT_DEPTH = 16;

    // Configuration port
    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     SCR_W_RST = 14'd1920;
    localparam logic [CFG_W-1:0]     SCR_H_RST = 14'd1080;

    // Request modes
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_PROJECT = 1'b1;

    // Fixed-point format
    localparam int FRAC_BITS_DEF = 16;
    localparam int NDC_INT_BITS  = 16;

    // Shared multiplier operand width (32-bit signed plus one guard bit)
    localparam int MUL_W = DATA_W + 1;

    // Tag that travels with each product to pick its accumulator
    typedef struct packed {
        logic       scale;  // 0: clip row sum, 1: viewport scaling
        logic [1:0] sel;    // clip: matrix row; scale: {lane, high half}
    } t_mul_tag;

endpackage

>>> src/wsp_in_if.sv
// ============================================================================
// wsp_in_if: request channel of the screen projection block
// Valid/ready handshake with one load or project request as payload.
// ============================================================================
interface wsp_in_if;
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic        [wsp_pkg::IDX_W-1:0]    coef_index;
    logic signed [wsp_pkg::DATA_W-1:0]   coef_value;
    logic signed [wsp_pkg::DATA_W-1:0]   pos_x;
    logic signed [wsp_pkg::DATA_W-1:0]   pos_y;
    logic signed [wsp_pkg::DATA_W-1:0]   pos_z;

    modport source (
        output valid, mode, coef_index, coef_value, pos_x, pos_y, pos_z,
        input  ready
    );
    modport sink (
        input  valid, mode, coef_index, coef_value, pos_x, pos_y, pos_z,
        output ready
    );
endinterface

>>> src/wsp_out_if.sv
// ============================================================================
// wsp_out_if: result channel of the screen projection block
// Valid/ready handshake carrying the visibility flag and pixel position.
// ============================================================================
interface wsp_out_if;
    logic                               valid;
    logic                               ready;
    logic                               on_screen;
    logic signed [wsp_pkg::PIX_W-1:0]   screen_x;
    logic signed [wsp_pkg::PIX_W-1:0]   screen_y;

    modport source (
        output valid, on_screen, screen_x, screen_y,
        input  ready
    );
    modport sink (
        input  valid, on_screen, screen_x, screen_y,
        output ready
    );
endinterface

>>> src/wsp_mul.sv
// ============================================================================
// wsp_mul: shared signed multiplier
// One 33x33 signed product per cycle, registered together with its tag.
// ============================================================================
module wsp_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  wsp_pkg::t_mul_tag                   i_tag,
    input  logic signed [wsp_pkg::MUL_W-1:0]    i_a,
    input  logic signed [wsp_pkg::MUL_W-1:0]    i_b,
    output logic                                o_valid,
    output wsp_pkg::t_mul_tag                   o_tag,
    output logic signed [2*wsp_pkg::MUL_W-1:0]  o_prod
);

    logic                                r_valid;
    wsp_pkg::t_mul_tag                   r_tag;
    logic signed [2*wsp_pkg::MUL_W-1:0]  r_prod;

    // Track which cycles carry a product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Register product and tag
    always_ff @(posedge i_clk) begin
        r_tag  <= i_tag;
        r_prod <= i_a * i_b;
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_prod  = r_prod;

endmodule

>>> src/wsp_div.sv
// ============================================================================
// wsp_div: two-lane restoring divider for the normalized coordinates
// Both lanes share one divisor and retire one quotient bit per cycle.
// ============================================================================
module wsp_div #(
    parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF,
    parameter int NUM_W     = 2 * wsp_pkg::DATA_W + 2 - FRAC_BITS
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_start,
    input  logic [NUM_W-1:0]                                     i_num [2],
    input  logic [NUM_W-2:0]                                     i_den,
    output logic                                                 o_done,
    output logic [wsp_pkg::NDC_INT_BITS+FRAC_BITS:0]             o_quo [2]
);

    localparam int K     = wsp_pkg::NDC_INT_BITS + FRAC_BITS;
    localparam int CNT_W = $clog2(K + 1);
    localparam int REM_W = NUM_W - 1;
    localparam int SH_W  = wsp_pkg::NDC_INT_BITS;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [REM_W-1:0] r_den;
    logic [REM_W-1:0] r_rem   [2];
    logic [SH_W-1:0]  r_sh    [2];
    logic [K-1:0]     r_q     [2];
    logic             r_clamp [2];

    logic [NUM_W-1:0] w_trial [2];
    logic             w_ge    [2];

    // Trial subtract per lane: shift in the next dividend bit, compare
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_trial[l] = {r_rem[l], r_sh[l][SH_W-1]};
            w_ge[l]    = w_trial[l] >= {1'b0, r_den};
        end
    end

    // Sequence the K quotient steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(K);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load operands, then restore or keep the partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            for (int l = 0; l < 2; l++) begin
                // Integer part of 65536 or more clamps the lane
                r_clamp[l] <= (i_num[l] >> SH_W) >= NUM_W'(i_den);
                r_rem[l]   <= REM_W'(i_num[l] >> SH_W);
                r_sh[l]    <= i_num[l][SH_W-1:0];
                r_q[l]     <= '0;
            end
        end else if (r_busy) begin
            for (int l = 0; l < 2; l++) begin
                r_rem[l] <= w_ge[l] ? REM_W'(w_trial[l] - {1'b0, r_den})
                                    : REM_W'(w_trial[l]);
                r_sh[l]  <= {r_sh[l][SH_W-2:0], 1'b0};
                r_q[l]   <= {r_q[l][K-2:0], w_ge[l]};
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            o_quo[l] = r_clamp[l] ? {1'b1, K'(0)} : {1'b0, r_q[l]};
        end
    end

    assign o_done = r_done;

endmodule

>>> src/world_to_screen_projection.sv
// ============================================================================
// world_to_screen_projection: 4x4 view matrix and viewport transform
// Loads view-matrix coefficients and projects world points to pixels.
// ============================================================================
//
//  Port          | Dir | Handshake         | Carries
//  --------------+-----+-------------------+--------------------------------
//  i_req         | in  | valid / ready     | mode, coef_index, coef_value,
//                |     |                   | pos_x, pos_y, pos_z
//  o_rsp         | out | valid / ready     | on_screen, screen_x, screen_y
//  i_cfg_*       | in  | write enable only | screen_width, screen_height
//
//  A load request is taken and gives no result.
//  A project request runs nine products through the shared multiplier, a
//  visibility check, the serial divider and four scaling products; values
//  are Q16.16 at the default FRAC_BITS. A point behind the near limit
//  skips the divider and the scaling products.
//  One project request is in flight at a time; the result sits in an output
//  register, and the next request is taken while it waits.
//  Reset clears the view matrix and loads a 1920 x 1080 viewport.
//
module world_to_screen_projection #(
    parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    wsp_in_if.sink                            i_req,
    wsp_out_if.source                         o_rsp,
    input  logic                              i_cfg_we,
    input  logic [wsp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wsp_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int DW    = wsp_pkg::DATA_W;
    localparam int MW    = wsp_pkg::MUL_W;
    localparam int CW    = 2 * DW + 2 - FRAC_BITS;          // clip sum width
    localparam int QW    = wsp_pkg::NDC_INT_BITS + FRAC_BITS + 1;
    localparam int HW    = wsp_pkg::CFG_W - 1;              // half viewport
    localparam int PW    = HW + QW;                         // scaled magnitude
    localparam int MAG_W = PW + 1 - FRAC_BITS;
    localparam int PIXW  = wsp_pkg::PIX_W;
    localparam int PIX_MAX = 2 ** (PIXW - 1) - 1;
    localparam int PIX_MIN = -(2 ** (PIXW - 1));
    localparam logic signed [CW+3:0] VIS_MIN = (CW+4)'(1) << FRAC_BITS;
    localparam logic [PW:0] RND = (PW+1)'((1 << FRAC_BITS) - 1);
    localparam int LO_W  = wsp_pkg::NDC_INT_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_MWAIT, S_CHECK, S_DIV, S_SCALE, S_SWAIT, S_FIN
    } t_state;

    t_state                    r_state;
    logic [1:0]                r_row;
    logic [1:0]                r_col;
    logic [1:0]                r_cnt;
    logic                      r_vis;
    logic                      r_neg [2];

    logic signed [DW-1:0]      r_mat [wsp_pkg::MAT_DEPTH];
    logic signed [DW-1:0]      r_pos [3];
    logic [wsp_pkg::CFG_W-1:0] r_scr_w;
    logic [wsp_pkg::CFG_W-1:0] r_scr_h;

    logic signed [CW-1:0]      r_cx;
    logic signed [CW-1:0]      r_cy;
    logic signed [CW-1:0]      r_cw;
    logic [PW-1:0]             r_p [2];

    logic                      r_out_valid;
    logic                      r_out_vis;
    logic signed [PIXW-1:0]    r_out_x;
    logic signed [PIXW-1:0]    r_out_y;

    logic                      w_req_acc;
    logic                      w_out_free;
    logic                      w_mul_go;
    wsp_pkg::t_mul_tag         w_mul_tag;
    logic signed [MW-1:0]      w_mul_a;
    logic signed [MW-1:0]      w_mul_b;
    logic                      mul_vld;
    wsp_pkg::t_mul_tag         mul_tag;
    logic signed [2*MW-1:0]    mul_prod;
    logic signed [CW-1:0]      w_prod_sh;

    logic signed [CW+3:0]      w_cw_ext;
    logic signed [CW+3:0]      w_cw10;
    logic                      w_vis;
    logic [CW-1:0]             w_num [2];
    logic                      w_div_start;
    logic                      div_done;
    logic [QW-1:0]             div_quo [2];
    logic [HW-1:0]             w_hw;
    logic [HW-1:0]             w_hh;

    // Round the scaled magnitude, apply sign and offset, saturate to 16 bits
    function automatic logic signed [PIXW-1:0] fin_pix(
        input logic [PW-1:0] p,
        input logic          neg,
        input logic [HW-1:0] h
    );
        logic [PW:0]              up;
        logic [MAG_W-1:0]         mag;
        logic signed [MAG_W+1:0]  v;
        up  = {1'b0, p} + RND;
        mag = neg ? MAG_W'(up >> FRAC_BITS) : MAG_W'(p >> FRAC_BITS);
        v   = $signed({2'b00, mag});
        if (neg) begin
            v = -v;
        end
        v = v + $signed((MAG_W+2)'(h));
        if (v > PIX_MAX) begin
            fin_pix = PIXW'(PIX_MAX);
        end else if (v < PIX_MIN) begin
            fin_pix = PIXW'(PIX_MIN);
        end else begin
            fin_pix = PIXW'(v);
        end
    endfunction

    assign w_req_acc  = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_hw = r_scr_w[wsp_pkg::CFG_W-1:1];
    assign w_hh = r_scr_h[wsp_pkg::CFG_W-1:1];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= wsp_pkg::SCR_W_RST;
            r_scr_h <= wsp_pkg::SCR_H_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wsp_pkg::CFG_SCREEN_WIDTH:  r_scr_w <= i_cfg_data;
                wsp_pkg::CFG_SCREEN_HEIGHT: r_scr_h <= i_cfg_data;
            endcase
        end
    end

    // View matrix: write one coefficient per load request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < wsp_pkg::MAT_DEPTH; i++) begin
                r_mat[i] <= '0;
            end
        end else if (w_req_acc && i_req.mode == wsp_pkg::MODE_LOAD) begin
            r_mat[i_req.coef_index] <= i_req.coef_value;
        end
    end

    // Select multiplier operands for the current step
    always_comb begin
        w_mul_go  = 1'b0;
        w_mul_tag = '0;
        w_mul_a   = '0;
        w_mul_b   = '0;
        unique case (r_state)
            S_MUL: begin
                w_mul_go        = 1'b1;
                w_mul_tag.scale = 1'b0;
                w_mul_tag.sel   = r_row;
                w_mul_a         = MW'(r_pos[r_col]);
                w_mul_b         = MW'(r_mat[{r_row, r_col}]);
            end
            S_SCALE: begin
                w_mul_go        = 1'b1;
                w_mul_tag.scale = 1'b1;
                w_mul_tag.sel   = r_cnt;
                w_mul_a         = r_cnt[1] ? MW'(w_hh) : MW'(w_hw);
                w_mul_b         = r_cnt[0] ? MW'(div_quo[r_cnt[1]][QW-1:LO_W])
                                           : MW'(div_quo[r_cnt[1]][LO_W-1:0]);
            end
            default: begin
                w_mul_go = 1'b0;
            end
        endcase
    end

    wsp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mul_go),
        .i_tag   (w_mul_tag),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_valid (mul_vld),
        .o_tag   (mul_tag),
        .o_prod  (mul_prod)
    );

    // Floor shift of each matrix product back to the fixed-point grid
    assign w_prod_sh = CW'(mul_prod >>> FRAC_BITS);

    // Visibility: w >= 0.1, checked as 10 * w >= 1.0 in fixed point
    assign w_cw_ext = (CW+4)'(r_cw);
    assign w_cw10   = (w_cw_ext <<< 3) + (w_cw_ext <<< 1);
    assign w_vis    = w_cw10 >= VIS_MIN;

    // Magnitudes of clip x and y for the divider
    assign w_num[0] = r_cx[CW-1] ? CW'(-r_cx) : CW'(r_cx);
    assign w_num[1] = r_cy[CW-1] ? CW'(-r_cy) : CW'(r_cy);
    assign w_div_start = (r_state == S_CHECK) && w_vis;

    wsp_div #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_cw[CW-2:0]),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Accumulate products into clip sums or scaled magnitudes
    always_ff @(posedge i_clk) begin
        if (w_req_acc && i_req.mode == wsp_pkg::MODE_PROJECT) begin
            r_pos[0] <= i_req.pos_x;
            r_pos[1] <= i_req.pos_y;
            r_pos[2] <= i_req.pos_z;
            r_cx     <= CW'(r_mat[3]);
            r_cy     <= CW'(r_mat[7]);
            r_cw     <= CW'(r_mat[15]);
        end else if (mul_vld && !mul_tag.scale) begin
            unique case (mul_tag.sel)
                2'd0:    r_cx <= r_cx + w_prod_sh;
                2'd1:    r_cy <= r_cy + w_prod_sh;
                2'd3:    r_cw <= r_cw + w_prod_sh;
                default: r_cw <= r_cw;
            endcase
        end
        if (r_state == S_CHECK) begin
            r_p[0]   <= '0;
            r_p[1]   <= '0;
            r_neg[0] <= r_cx[CW-1];
            // Screen y is flipped, so the sign of the row result inverts
            r_neg[1] <= !r_cy[CW-1];
        end else if (mul_vld && mul_tag.scale) begin
            r_p[mul_tag.sel[1]] <= r_p[mul_tag.sel[1]] +
                (mul_tag.sel[0] ? (PW'(mul_prod) << LO_W) : PW'(mul_prod));
        end
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_vis       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_vis   <= 1'b0;
            r_out_x     <= '0;
            r_out_y     <= '0;
        end else begin
            // Drop the taken result unless a new one loads in this cycle
            if (o_rsp.ready && !(r_state == S_FIN && w_out_free)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_req_acc && i_req.mode == wsp_pkg::MODE_PROJECT) begin
                        r_row   <= 2'd0;
                        r_col   <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // Walk columns 0..2 of rows 0, 1 and 3
                    if (r_col == 2'd2) begin
                        r_col <= 2'd0;
                        r_row <= (r_row == 2'd1) ? 2'd3 : r_row + 2'd1;
                        if (r_row == 2'd3) begin
                            r_state <= S_MWAIT;
                        end
                    end else begin
                        r_col <= r_col + 2'd1;
                    end
                end
                S_MWAIT: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_vis   <= w_vis;
                    r_state <= w_vis ? S_DIV : S_FIN;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_cnt   <= 2'd0;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= S_SWAIT;
                    end
                end
                S_SWAIT: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // Hold until the output register is free
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_vis   <= r_vis;
                        r_out_x     <= r_vis ? fin_pix(r_p[0], r_neg[0], w_hw) : '0;
                        r_out_y     <= r_vis ? fin_pix(r_p[1], r_neg[1], w_hh) : '0;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.on_screen = r_out_vis;
    assign o_rsp.screen_x  = r_out_x;
    assign o_rsp.screen_y  = r_out_y;

    // Divider completes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide phase");

    // Products arrive only in the multiply phases or the cycle after
    a_mul_in_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_vld |-> (r_state == S_MUL || r_state == S_MWAIT ||
                     r_state == S_SCALE || r_state == S_SWAIT))
        else $error("product arrived outside a multiply phase");

    // A hidden point reports the origin
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.on_screen) |-> (o_rsp.screen_x == '0 &&
                                               o_rsp.screen_y == '0))
        else $error("hidden point with nonzero position");

    // A project request starts the matrix products at once
    a_project_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_acc && i_req.mode == wsp_pkg::MODE_PROJECT) |=> r_state == S_MUL)
        else $error("project request did not start the multiply phase");

endmodule
